// ===== rtl/sde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sde_pkg;

	// Sample and register widths
	localparam int SAMPLE_BITS   = 24;
	localparam int MAG_BITS      = SAMPLE_BITS - 1;
	localparam int RATIO_BITS    = 12;
	localparam int CFG_BITS      = MAG_BITS;
	localparam int CFG_IDX_BITS  = 1;

	// Table geometry: only the largest power of two within TABLE_ENTRIES is used
	localparam int TABLE_ENTRIES = 256;
	localparam int TAB_BITS      = $clog2(TABLE_ENTRIES + 1) - 1;
	localparam int TAB_SIZE      = 1 << TAB_BITS;

	// Log domain: position of the leading one plus 16 fraction bits
	localparam int FRAC_BITS     = 16;
	localparam int P_BITS        = $clog2(MAG_BITS);
	localparam int LOG_BITS      = P_BITS + FRAC_BITS;
	localparam int E_BITS        = LOG_BITS + RATIO_BITS - 8;
	localparam int N_BITS        = E_BITS - FRAC_BITS;

	// Exp table entries in Q1.30
	localparam int EXP_FRAC      = 30;
	localparam int EXP_W         = EXP_FRAC + 1;
	localparam int PROD_BITS     = MAG_BITS + EXP_W;

	// Register reset values
	localparam logic [MAG_BITS-1:0]   THRESHOLD_RST = MAG_BITS'(838861);
	localparam logic [RATIO_BITS-1:0] RATIO_RST     = RATIO_BITS'(512);

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RATIO     = 1'b1;

	typedef logic [FRAC_BITS-1:0] log_tab_t [TAB_SIZE];
	typedef logic [EXP_W-1:0]     exp_tab_t [TAB_SIZE];

	// Integer square root, digit by digit
	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		logic [63:0] x;
		x = v;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (b > x) b = b >> 2;
		end
		for (int k = 0; k < 32; k++) begin
			if (b != 64'd0) begin
				if (x >= r + b) begin
					x = x - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// Fraction of log2(1 + i/2^B) by repeated squaring in Q1.30
	function automatic log_tab_t build_log_tab();
		log_tab_t t;
		logic [63:0] v;
		logic [FRAC_BITS-1:0] f;
		for (int i = 0; i < TAB_SIZE; i++) begin
			v = 64'(TAB_SIZE + i) << (EXP_FRAC - TAB_BITS);
			f = '0;
			for (int k = 0; k < FRAC_BITS; k++) begin
				v = (v * v) >> EXP_FRAC;
				f = {f[FRAC_BITS-2:0], 1'b0};
				if (v >= (64'd2 << EXP_FRAC)) begin
					f[0] = 1'b1;
					v = v >> 1;
				end
			end
			t[i] = f;
		end
		return t;
	endfunction

	// 2^(-i/2^B) in Q1.30 as a product of repeated square roots of one half
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t t;
		logic [63:0] rt [16];
		logic [63:0] acc;
		for (int m = 0; m < 16; m++) rt[m] = 64'd0;
		rt[1] = isqrt64(64'd1 << 59);
		for (int m = 1; m < 15; m++) rt[m + 1] = isqrt64(rt[m] << EXP_FRAC);
		for (int i = 0; i < TAB_SIZE; i++) begin
			acc = 64'd1 << EXP_FRAC;
			for (int k = 0; k < TAB_BITS; k++) begin
				if (((i >> k) & 1) != 0) acc = (acc * rt[TAB_BITS - k]) >> EXP_FRAC;
			end
			t[i] = acc[EXP_W-1:0];
		end
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

	// Position of the leading one
	function automatic logic [P_BITS-1:0] lead_pos(input logic [MAG_BITS-1:0] v);
		logic [P_BITS-1:0] p;
		p = '0;
		for (int b = 0; b < MAG_BITS; b++) begin
			if (v[b]) p = P_BITS'(b);
		end
		return p;
	endfunction

	// Table index: the bits just below the leading one, zero filled
	function automatic logic [TAB_BITS-1:0] norm_idx(input logic [MAG_BITS-1:0] v,
			input logic [P_BITS-1:0] p);
		logic [MAG_BITS-1:0] s;
		s = v << (P_BITS'(MAG_BITS - 1) - p);
		return s[MAG_BITS-2 -: TAB_BITS];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/static_downward_expander.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Static downward expander for a stream of signed Q1.23 samples.
// Input channel: in_valid / in_sample, held off by in_stall. Output channel:
// out_valid / y_sample / expanded, held off by out_stall. An item moves on
// a rising edge with valid high and stall low.
// A sample at or above the threshold passes unchanged (expanded = 0); a
// smaller one becomes threshold*(|x|/threshold)^ratio, at most |x|, sign kept.
// Throughput: one item per cycle while the output is not stalled. An accepted
// item passes through seven register stages: magnitude, leading-one normalize,
// log table and subtract, ratio multiply, exp table, threshold multiply, shift
// and clamp.
// When out_stall is high the last stage holds its item; earlier stages keep
// moving into empty slots, and in_stall rises only once every stage is full.
// Reset empties the pipeline and loads threshold 838861 and ratio 2.0.
// The user must write configuration (cfg_wen, cfg_idx, cfg_wdata) only while no
// item is in flight; nothing enforces it. Index 0: threshold, 1: ratio in Q4.8.
module static_downward_expander (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wen,
	input  wire logic [sde_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
	input  wire logic [sde_pkg::CFG_BITS-1:0]         cfg_wdata,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [sde_pkg::SAMPLE_BITS-1:0] in_sample,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [sde_pkg::SAMPLE_BITS-1:0]    y_sample,
	output logic                                      expanded
);

	localparam int SB = sde_pkg::SAMPLE_BITS;
	localparam int MB = sde_pkg::MAG_BITS;

	// Configuration registers
	logic [MB-1:0]                  threshold_q;
	logic [sde_pkg::RATIO_BITS-1:0] ratio_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= sde_pkg::THRESHOLD_RST;
			ratio_q     <= sde_pkg::RATIO_RST;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				sde_pkg::REG_THRESHOLD: threshold_q <= cfg_wdata;
				sde_pkg::REG_RATIO:     ratio_q     <= cfg_wdata[sde_pkg::RATIO_BITS-1:0];
			endcase
		end
	end

	// Stage enables: a stage moves when empty or when the next one moves
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6, en7;

	assign en7      = !out_valid || !out_stall;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			v_s6      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) out_valid <= v_s6;
		end
	end

	// Pipeline payload
	logic [SB-1:0]                 raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, raw_s6;
	logic [SB-1:0]                 mag_s1;
	logic                          neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic                          pass_s2, pass_s3, pass_s4, pass_s5, pass_s6;
	logic [MB-1:0]                 mag_s2, mag_s3, mag_s4, mag_s5, mag_s6;
	logic [sde_pkg::P_BITS-1:0]    pm_s2, pt_s2;
	logic [sde_pkg::TAB_BITS-1:0]  im_s2, it_s2;
	logic [sde_pkg::LOG_BITS-1:0]  d_s3;
	logic [sde_pkg::E_BITS-1:0]    e_s4;
	logic [sde_pkg::EXP_W-1:0]     et_s5;
	logic [sde_pkg::N_BITS-1:0]    n_s5, n_s6;
	logic [sde_pkg::PROD_BITS-1:0] prod_s6;

	// Combinational helpers
	logic [SB-1:0]                          in_mag;
	logic [sde_pkg::LOG_BITS-1:0]           log_t, log_m;
	logic [sde_pkg::LOG_BITS+sde_pkg::RATIO_BITS-1:0] dr_prod;
	logic [sde_pkg::TAB_BITS-1:0]           j_idx;
	logic [MB:0]                            res_sh;
	logic [MB:0]                            res_cl;
	logic [SB-1:0]                          res_signed;

	assign in_mag  = in_sample[SB-1] ? (~in_sample + SB'(1)) : in_sample;
	assign log_t   = {pt_s2, sde_pkg::LOG_TAB[it_s2]};
	assign log_m   = {pm_s2, sde_pkg::LOG_TAB[im_s2]};
	assign dr_prod = d_s3 * ratio_q;
	assign j_idx   = e_s4[sde_pkg::FRAC_BITS-1 -: sde_pkg::TAB_BITS];

	// Final shift by the integer part, then clamp so no sample grows
	assign res_sh     = prod_s6[sde_pkg::PROD_BITS-1:sde_pkg::EXP_FRAC] >> n_s6;
	assign res_cl     = (res_sh > {1'b0, mag_s6}) ? {1'b0, mag_s6} : res_sh;
	assign res_signed = neg_s6 ? (~SB'(res_cl) + SB'(1)) : SB'(res_cl);

	// s1: magnitude and sign
	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			raw_s1 <= in_sample;
			mag_s1 <= in_mag;
			neg_s1 <= in_sample[SB-1];
		end
	end

	// s2: threshold compare and leading-one normalize of both operands
	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			raw_s2  <= raw_s1;
			neg_s2  <= neg_s1;
			pass_s2 <= mag_s1 >= {1'b0, threshold_q};
			mag_s2  <= mag_s1[MB-1:0];
			pm_s2   <= sde_pkg::lead_pos(mag_s1[MB-1:0]);
			im_s2   <= sde_pkg::norm_idx(mag_s1[MB-1:0], sde_pkg::lead_pos(mag_s1[MB-1:0]));
			pt_s2   <= sde_pkg::lead_pos(threshold_q);
			it_s2   <= sde_pkg::norm_idx(threshold_q, sde_pkg::lead_pos(threshold_q));
		end
	end

	// s3: log difference
	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			raw_s3  <= raw_s2;
			neg_s3  <= neg_s2;
			pass_s3 <= pass_s2;
			mag_s3  <= mag_s2;
			d_s3    <= log_t - log_m;
		end
	end

	// s4: scale by the ratio, truncated
	always_ff @(posedge clk) begin
		if (en4 && v_s3) begin
			raw_s4  <= raw_s3;
			neg_s4  <= neg_s3;
			pass_s4 <= pass_s3;
			mag_s4  <= mag_s3;
			e_s4    <= dr_prod[sde_pkg::LOG_BITS+sde_pkg::RATIO_BITS-1:8];
		end
	end

	// s5: exp table on the fraction, keep the integer part
	always_ff @(posedge clk) begin
		if (en5 && v_s4) begin
			raw_s5  <= raw_s4;
			neg_s5  <= neg_s4;
			pass_s5 <= pass_s4;
			mag_s5  <= mag_s4;
			et_s5   <= sde_pkg::EXP_TAB[j_idx];
			n_s5    <= e_s4[sde_pkg::E_BITS-1:sde_pkg::FRAC_BITS];
		end
	end

	// s6: threshold times gain
	always_ff @(posedge clk) begin
		if (en6 && v_s5) begin
			raw_s6  <= raw_s5;
			neg_s6  <= neg_s5;
			pass_s6 <= pass_s5;
			mag_s6  <= mag_s5;
			n_s6    <= n_s5;
			prod_s6 <= threshold_q * et_s5;
		end
	end

	// s7: output register
	always_ff @(posedge clk) begin
		if (en7 && v_s6) begin
			y_sample <= pass_s6 ? raw_s6 : res_signed;
			expanded <= !pass_s6;
		end
	end

	// Magnitude of the held output, for checking
	logic [SB-1:0] out_mag;
	assign out_mag = y_sample[SB-1] ? (~y_sample + SB'(1)) : y_sample;

`ifndef ASSERT_OFF
	// Input is held off only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && out_valid && out_stall))
		else $error("in_stall with an empty stage");

	// An expanded sample always lies below the threshold
	a_exp_below: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && expanded) |-> (out_mag < {1'b0, threshold_q}))
		else $error("expanded sample at or above threshold");

	// A passed non-negative sample keeps a magnitude at or above the threshold
	a_pass_above: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !expanded) |-> ((out_mag >= {1'b0, threshold_q}) || y_sample[SB-1]))
		else $error("passed sample below threshold");
`endif

endmodule

`default_nettype wire

// ===== tb/static_downward_expander_tb.sv =====
`timescale 1ns / 1ps

module static_downward_expander_tb;

	localparam int LATENCY      = 7;
	localparam int SETTLE       = 3 * LATENCY;
	localparam int LIMIT_CYCLES = 600000;
	localparam int LUT_BITS     = sde_pkg::TAB_BITS;
	localparam int LUT_SIZE     = 1 << LUT_BITS;

	typedef logic signed [sde_pkg::SAMPLE_BITS-1:0] sample_t;

	// One expected output item
	typedef struct {
		sample_t sample;
		logic    expanded;
	} curve_out_t;

	// Expander curve predictor plus the queue of results still owed by the block
	class expander_scoreboard;
		logic [sde_pkg::MAG_BITS-1:0]   thr;
		logic [sde_pkg::RATIO_BITS-1:0] rat;
		logic [63:0]           log_frac [LUT_SIZE];
		logic [63:0]           pow_frac [LUT_SIZE];
		curve_out_t            awaited [$];
		int                    mismatches;
		int                    n_checked;
		int                    n_expanded;

		function new();
			logic [63:0] roots [16];
			logic [63:0] v;
			logic [63:0] f;
			logic [63:0] acc;
			thr = sde_pkg::THRESHOLD_RST;
			rat = sde_pkg::RATIO_RST;
			mismatches = 0;
			n_checked = 0;
			n_expanded = 0;
			for (int m = 0; m < 16; m++) roots[m] = 64'd0;
			// repeated square roots of one half, Q1.30
			roots[1] = root64(64'd1 << 59);
			for (int m = 1; m < 15; m++) roots[m + 1] = root64(roots[m] << 30);
			for (int i = 0; i < LUT_SIZE; i++) begin
				// log2 fraction by squaring 1 + i/2^B sixteen times
				v = 64'(LUT_SIZE + i) << (30 - LUT_BITS);
				f = 64'd0;
				for (int k = 0; k < 16; k++) begin
					v = (v * v) >> 30;
					f = f << 1;
					if (v >= (64'd2 << 30)) begin
						f = f | 64'd1;
						v = v >> 1;
					end
				end
				log_frac[i] = f;
				// 2^(-i/2^B) as a product of roots, truncated at each step
				acc = 64'd1 << 30;
				for (int k = 0; k < LUT_BITS; k++) begin
					if (((i >> k) & 1) != 0) acc = (acc * roots[LUT_BITS - k]) >> 30;
				end
				pow_frac[i] = acc;
			end
		endfunction

		function logic [63:0] root64(logic [63:0] x);
			logic [63:0] q;
			logic [63:0] one;
			q = 64'd0;
			one = 64'd1 << 62;
			while (one > x) one = one >> 2;
			while (one != 64'd0) begin
				if (x >= q + one) begin
					x = x - (q + one);
					q = (q >> 1) + one;
				end else begin
					q = q >> 1;
				end
				one = one >> 2;
			end
			return q;
		endfunction

		// Q5.16 log2: leading-one position plus table fraction
		function logic [63:0] log2_fix(logic [63:0] x);
			int p;
			logic [63:0] idx;
			p = 0;
			while (p < 63 && (x >> (p + 1)) != 64'd0) p++;
			if (p >= LUT_BITS) idx = x >> (p - LUT_BITS);
			else idx = x << (LUT_BITS - p);
			idx = idx & 64'(LUT_SIZE - 1);
			return (64'(p) << 16) + log_frac[idx[LUT_BITS-1:0]];
		endfunction

		function curve_out_t apply_curve(sample_t s);
			curve_out_t r;
			logic [sde_pkg::SAMPLE_BITS-1:0] m24;
			logic [63:0] mag, res, d, e, n, j, sh;
			logic neg;
			neg = s[sde_pkg::SAMPLE_BITS-1];
			m24 = neg ? (~s + 1'b1) : s;
			mag = 64'(m24);
			if (mag >= 64'(thr)) begin
				r.sample = s;
				r.expanded = 1'b0;
				return r;
			end
			if (mag == 64'd0) begin
				res = 64'd0;
			end else begin
				d = log2_fix(64'(thr)) - log2_fix(mag);
				e = (d * 64'(rat)) >> 8;
				n = e >> 16;
				j = (e & 64'hFFFF) >> (16 - LUT_BITS);
				sh = 64'd30 + n;
				res = (sh >= 64'd63) ? 64'd0 :
					((64'(thr) * pow_frac[j[LUT_BITS-1:0]]) >> sh);
				// no sample may grow
				if (res > mag) res = mag;
			end
			r.sample = neg ? sample_t'(~res + 64'd1) : sample_t'(res);
			r.expanded = 1'b1;
			return r;
		endfunction

		function void note_input(sample_t s);
			awaited.push_back(apply_curve(s));
		endfunction

		task flag_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_result(sample_t got_s, logic got_e);
			curve_out_t want;
			if (awaited.size() == 0) begin
				flag_mismatch($sformatf("result %0d with nothing outstanding", got_s));
				return;
			end
			want = awaited.pop_front();
			n_checked++;
			if (want.expanded) n_expanded++;
			if (got_s !== want.sample)
				flag_mismatch($sformatf("y_sample %0d, want %0d", got_s, want.sample));
			if (got_e !== want.expanded)
				flag_mismatch($sformatf("expanded %b, want %b", got_e, want.expanded));
		endtask
	endclass

	logic                             clk;
	logic                             arst_n    = 1'b0;
	logic                             cfg_wen   = 1'b0;
	logic [sde_pkg::CFG_IDX_BITS-1:0] cfg_idx   = sde_pkg::REG_THRESHOLD;
	logic [sde_pkg::CFG_BITS-1:0]     cfg_wdata = '0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	sample_t                          in_sample = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	sample_t                          y_sample;
	logic                             expanded;

	expander_scoreboard sb = new();

	int   burst_left = 0;
	int   samples_in = 0;
	int   settings   = 1;
	int   rx_mode    = 0;
	int   rx_left    = 0;
	logic rx_next    = 1'b0;
	logic long_hold  = 1'b0;
	bit   hold_arm   = 1'b0;

	static_downward_expander i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_sample (in_sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.y_sample  (y_sample),
		.expanded  (expanded)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Output side: check accepted items, then pick next stall from current pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(y_sample, expanded);
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(1, 64);
		end
		rx_left--;
		case (rx_mode)
			0: rx_next = 1'b0;
			1: rx_next = ($urandom_range(0, 3) == 0);
			2: rx_next = ($urandom_range(0, 1) == 1);
			default: rx_next = ($urandom_range(0, 7) != 0);
		endcase
		out_stall <= long_hold || rx_next;
	end

	// Long output hold-off while the sender keeps going, to back up the pipeline
	initial begin
		wait (hold_arm);
		repeat (15) @(posedge clk);
		long_hold <= 1'b1;
		repeat (300) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#(LIMIT_CYCLES * 10);
		$display("timeout: %0d items outstanding", sb.awaited.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Offer one item, pacing the input in bursts with random gaps
	task automatic push_sample(input sample_t s);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_sample <= s;
		do @(posedge clk); while (in_stall);
		sb.note_input(s);
		burst_left--;
		samples_in++;
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic drain();
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Both registers back to back; ratio gets junk above its 12 bits
	task automatic write_regs(input logic [sde_pkg::MAG_BITS-1:0] t,
			input logic [sde_pkg::RATIO_BITS-1:0] r);
		cfg_wen <= 1'b1;
		cfg_idx <= sde_pkg::REG_THRESHOLD;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_idx <= sde_pkg::REG_RATIO;
		cfg_wdata <= {(sde_pkg::CFG_BITS - sde_pkg::RATIO_BITS)'($urandom), r};
		@(posedge clk);
		cfg_wen <= 1'b0;
		sb.thr = t;
		sb.rat = r;
		settings++;
	endtask

	// Zero, unit, full scale and the samples around the threshold
	task automatic push_edges(input logic [sde_pkg::MAG_BITS-1:0] t);
		int tv;
		tv = int'(t);
		push_sample(sample_t'(0));
		push_sample(sample_t'(1));
		push_sample(sample_t'(-1));
		push_sample(sample_t'(24'h7FFFFF));
		push_sample(sample_t'(24'h800000));
		push_sample(sample_t'(tv - 1));
		push_sample(sample_t'(-(tv - 1)));
		push_sample(sample_t'(tv));
		push_sample(sample_t'(-tv));
		push_sample(sample_t'(tv + 1));
	endtask

	// Most often a sample under the threshold, else small ones, near misses or raw noise
	function automatic sample_t pick_sample(input logic [sde_pkg::MAG_BITS-1:0] t);
		int k;
		int v;
		k = $urandom_range(0, 99);
		if (k < 45 && t > 1) begin
			v = $urandom_range(0, int'(t) - 1);
		end else if (k < 62) begin
			v = $urandom & ((1 << $urandom_range(0, 22)) - 1);
		end else if (k < 77) begin
			v = int'(t) + int'($urandom_range(0, 8)) - 4;
			if (v < 0) v = 0;
			if (v > 8388607) v = 8388607;
		end else begin
			return sample_t'($urandom);
		end
		return $urandom_range(0, 1) ? sample_t'(-v) : sample_t'(v);
	endfunction

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) push_sample(pick_sample(sb.thr));
	endtask

	initial begin
		logic [sde_pkg::MAG_BITS-1:0]   t;
		logic [sde_pkg::RATIO_BITS-1:0] r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: edges plus a few bit patterns
		push_edges(sb.thr);
		push_sample(sample_t'(2));
		push_sample(sample_t'(255));
		push_sample(sample_t'(256));
		push_sample(sample_t'(4096));
		push_sample(sample_t'(-4096));
		push_sample(sample_t'(24'h555555));
		push_sample(sample_t'(24'hAAAAAA));
		run_random(160);

		// Fixed corners, then random settings
		for (int ph = 0; ph < 10; ph++) begin
			end_stream();
			drain();
			case (ph)
				0: begin t = 23'h7FFFFF; r = 12'd4095; end
				1: begin t = 23'h7FFFFF; r = 12'd257;  end
				2: begin t = 23'd1;      r = 12'd257;  end
				3: begin t = 23'd0;      r = 12'd256;  end // threshold zero: all pass
				4: begin t = 23'd5000000; r = 12'd128; end // ratio below one: clamp
				5: begin t = 23'($urandom_range(1, 2000)); r = 12'd4095; end
				default: begin
					t = 23'($urandom_range(1, 8388607));
					r = 12'($urandom_range(257, 4095));
				end
			endcase
			write_regs(t, r);
			push_edges(t);
			if (ph == 6) hold_arm = 1'b1;
			run_random((ph == 2 || ph == 3) ? 40 : 160);
		end
		end_stream();
		drain();

		if (sb.awaited.size() != 0)
			sb.flag_mismatch($sformatf("%0d results never came out", sb.awaited.size()));
		$display("covered %0d samples under %0d register settings", samples_in, settings);
		$display("%0d results checked, %0d of them on the expansion curve",
			sb.n_checked, sb.n_expanded);
		if (sb.mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
